/* rtl/brn_pkg.sv */
package brn_pkg;

    localparam int NumW    = 12;
    localparam int LetterW = 7;
    localparam int Places  = 4;

    localparam logic [NumW-1:0] MaxValue = 12'd3999;

    // ASCII numeral letters
    localparam logic [LetterW-1:0] LetI    = 7'h49;
    localparam logic [LetterW-1:0] LetV    = 7'h56;
    localparam logic [LetterW-1:0] LetX    = 7'h58;
    localparam logic [LetterW-1:0] LetL    = 7'h4C;
    localparam logic [LetterW-1:0] LetC    = 7'h43;
    localparam logic [LetterW-1:0] LetD    = 7'h44;
    localparam logic [LetterW-1:0] LetM    = 7'h4D;
    localparam logic [LetterW-1:0] LetNone = 7'h00;

    typedef logic [3:0] digit_t;
    typedef logic [1:0] place_t;
    typedef logic [2:0] dlen_t;

    // dig[0] thousands .. dig[3] units
    typedef struct packed {
        logic                  err;
        digit_t [Places-1:0]   dig;
    } digits_t;

    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN
    } sym_sel_t;

    // letters a decimal digit expands to
    function automatic dlen_t digit_len(digit_t d);
        dlen_t n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // symbol of letter k within a digit's pattern
    function automatic sym_sel_t shape_sel(digit_t d, logic [1:0] k);
        sym_sel_t s;
        case (d)
            4'd4:             s = (k == 2'd0) ? SEL_ONE : SEL_FIVE;
            4'd5:             s = SEL_FIVE;
            4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? SEL_FIVE : SEL_ONE;
            4'd9:             s = (k == 2'd0) ? SEL_ONE : SEL_TEN;
            default:          s = SEL_ONE;
        endcase
        return s;
    endfunction

    function automatic logic [LetterW-1:0] place_letter(place_t p, sym_sel_t s);
        logic [LetterW-1:0] l;
        case (p)
            2'd0: l = LetM;
            2'd1:
            begin
                case (s)
                    SEL_ONE:  l = LetC;
                    SEL_FIVE: l = LetD;
                    default:  l = LetM;
                endcase
            end
            2'd2:
            begin
                case (s)
                    SEL_ONE:  l = LetX;
                    SEL_FIVE: l = LetL;
                    default:  l = LetC;
                endcase
            end
            default:
            begin
                case (s)
                    SEL_ONE:  l = LetI;
                    SEL_FIVE: l = LetV;
                    default:  l = LetX;
                endcase
            end
        endcase
        return l;
    endfunction

endpackage

/* rtl/binary_to_roman_numeral.sv */
// Binary to Roman numeral converter.
//
// Input channel: drive number and raise start; the item is taken at a rising
// edge where start is high and busy is low. Numbers 1 to 3999 convert; zero
// and 4000 to 4095 are range errors.
//
// Result channel: one ASCII letter per cycle, most significant digit first,
// each marked by strobe for exactly one cycle. last flags the final letter of
// an item. An out-of-range item gives one result: letter 0, range_error and
// last set. The receiver cannot stall; strobe is never held off.
//
// The first letter of an item passes the range check and thousands stage,
// the hundreds stage, the tens and units stage and the letter sequencer.
// Throughput: the letter sequencer emits one letter per cycle, so an item
// gives 1 to 15 letters (15 for 3888); when the next item is waiting, its
// first letter follows the previous last letter with no gap. Items queue in
// the three digit stages while a long numeral drains; busy rises when they fill.
//
// Reset: rst_n clears all stage valid bits and the sequencer; busy is low
// and no strobe is shown until an item is accepted.
module binary_to_roman_numeral
    import brn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NumW-1:0]    number,
    output logic               busy,
    output logic               strobe,
    output logic [LetterW-1:0] letter,
    output logic               range_error,
    output logic               last
);

    // digit pipeline -> letter sequencer
    logic    dig_valid;
    logic    dig_ready;
    digits_t dig_item;

    // three stages: thousands, hundreds, tens/units
    brn_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .number    (number),
        .busy      (busy),
        .out_valid (dig_valid),
        .out_item  (dig_item),
        .out_ready (dig_ready)
    );

    // walks places and letters within each digit, one letter per cycle
    brn_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (dig_valid),
        .in_item     (dig_item),
        .in_ready    (dig_ready),
        .strobe      (strobe),
        .letter      (letter),
        .range_error (range_error),
        .last        (last)
    );

endmodule

/* rtl/brn_split.sv */
module brn_split
    import brn_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [NumW-1:0] number,
    output logic            busy,
    output logic            out_valid,
    output digits_t         out_item,
    input  logic            out_ready
);

    // stage 1: range check, thousands
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_err_reg,   s1_err_next;
    digit_t     s1_thou_reg,  s1_thou_next;
    logic [9:0] s1_rem_reg,   s1_rem_next;
    // stage 2: hundreds
    logic       s2_valid_reg;
    logic       s2_err_reg;
    digit_t     s2_thou_reg;
    digit_t     s2_hund_reg,  s2_hund_next;
    logic [6:0] s2_rem_reg,   s2_rem_next;
    // stage 3: tens and units
    logic       s3_valid_reg;
    digits_t    s3_item_reg,  s3_item_next;

    logic s1_free, s2_free, s3_free;

    assign s3_free = !s3_valid_reg || out_ready;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_free = !s1_valid_reg || s2_free;
    assign busy    = !s1_free;

    always_comb
    begin
        logic [NumW-1:0] sub;
        s1_err_next = (number == '0) || (number > MaxValue);
        if (number >= 12'd3000)
        begin
            s1_thou_next = 4'd3;
            sub          = number - 12'd3000;
        end
        else if (number >= 12'd2000)
        begin
            s1_thou_next = 4'd2;
            sub          = number - 12'd2000;
        end
        else if (number >= 12'd1000)
        begin
            s1_thou_next = 4'd1;
            sub          = number - 12'd1000;
        end
        else
        begin
            s1_thou_next = 4'd0;
            sub          = number;
        end
        s1_rem_next   = sub[9:0];
        s1_valid_next = in_valid;
    end

    // independent compares against each hundred, last match wins
    always_comb
    begin
        s2_hund_next = 4'd0;
        s2_rem_next  = s1_rem_reg[6:0];
        for (int i = 1; i <= 9; i++)
        begin
            if (s1_rem_reg >= 10'(i * 100))
            begin
                s2_hund_next = 4'(i);
                s2_rem_next  = 7'(s1_rem_reg - 10'(i * 100));
            end
        end
    end

    always_comb
    begin
        logic [6:0] u;
        digit_t     t;
        t = 4'd0;
        u = s2_rem_reg;
        for (int i = 1; i <= 9; i++)
        begin
            if (s2_rem_reg >= 7'(i * 10))
            begin
                t = 4'(i);
                u = s2_rem_reg - 7'(i * 10);
            end
        end
        s3_item_next.err    = s2_err_reg;
        s3_item_next.dig[0] = s2_thou_reg;
        s3_item_next.dig[1] = s2_hund_reg;
        s3_item_next.dig[2] = t;
        s3_item_next.dig[3] = u[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= s1_valid_next;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_err_reg  <= s1_err_next;
            s1_thou_reg <= s1_thou_next;
            s1_rem_reg  <= s1_rem_next;
        end
        if (s2_free)
        begin
            s2_err_reg  <= s1_err_reg;
            s2_thou_reg <= s1_thou_reg;
            s2_hund_reg <= s2_hund_next;
            s2_rem_reg  <= s2_rem_next;
        end
        if (s3_free)
            s3_item_reg <= s3_item_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

/* rtl/brn_emit.sv */
module brn_emit
    import brn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  digits_t            in_item,
    output logic               in_ready,
    output logic               strobe,
    output logic [LetterW-1:0] letter,
    output logic               range_error,
    output logic               last
);

    logic       act_reg,   act_next;
    place_t     place_reg, place_next;
    logic [1:0] k_reg,     k_next;
    digits_t    item_reg;

    digit_t cur_d;
    logic   at_end;
    logic   nxt_found;
    place_t nxt_place;
    place_t first_place;
    logic   fin;
    logic   load;

    assign cur_d  = item_reg.dig[place_reg];
    assign at_end = ({1'b0, k_reg} + 3'd1) == digit_len(cur_d);

    // next place that still has letters
    always_comb
    begin
        nxt_found = 1'b0;
        nxt_place = place_reg;
        for (int p = Places - 1; p >= 0; p--)
        begin
            if ((2'(p) > place_reg) && (digit_len(item_reg.dig[p]) != 3'd0))
            begin
                nxt_found = 1'b1;
                nxt_place = 2'(p);
            end
        end
    end

    always_comb
    begin
        first_place = 2'd0;
        for (int p = Places - 1; p >= 0; p--)
        begin
            if (digit_len(in_item.dig[p]) != 3'd0)
                first_place = 2'(p);
        end
    end

    assign fin      = item_reg.err || (at_end && !nxt_found);
    assign in_ready = !act_reg || fin;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        act_next   = act_reg;
        place_next = place_reg;
        k_next     = k_reg;
        if (load)
        begin
            act_next   = 1'b1;
            place_next = first_place;
            k_next     = 2'd0;
        end
        else if (act_reg && fin)
            act_next = 1'b0;
        else if (act_reg && at_end)
        begin
            place_next = nxt_place;
            k_next     = 2'd0;
        end
        else if (act_reg)
            k_next = k_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            place_reg <= 2'd0;
            k_reg     <= 2'd0;
        end
        else
        begin
            act_reg   <= act_next;
            place_reg <= place_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    assign strobe      = act_reg;
    assign letter      = item_reg.err ? LetNone
                                      : place_letter(place_reg, shape_sel(cur_d, k_reg));
    assign range_error = item_reg.err;
    assign last        = fin;

endmodule

/* rtl/brn_checker.sv */
module brn_checker
    import brn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               busy,
    input  logic               strobe,
    input  logic [LetterW-1:0] letter,
    input  logic               range_error,
    input  logic               last
);

    // error item is a single terminal result with no letter
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && range_error |-> last && (letter == LetNone))
        else $error("range error result not single");

    a_letter_set: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !range_error |->
            (letter == LetI) || (letter == LetV) || (letter == LetX) ||
            (letter == LetL) || (letter == LetC) || (letter == LetD) ||
            (letter == LetM))
        else $error("letter not a numeral symbol");

    // a numeral goes out without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && !range_error)
        else $error("gap or error inside a numeral");

    // no strobe and no busy right after reset is released
    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !strobe && !busy)
        else $error("activity straight out of reset");

endmodule

bind binary_to_roman_numeral brn_checker u_brn_checker (.*);

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brn_pkg::*;

    // One letter as seen on the result ports.
    typedef struct packed {
        logic [LetterW-1:0] letter;
        logic               range_error;
        logic               last;
    } glyph_t;

    localparam int RandomItems = 280;
    // Worst case per item: 15 letters, the longest idle gap and the
    // pipeline. Taken several times over.
    localparam int CycleLimit  = 200000;
    // Watch time after the last expected letter, to catch stray letters.
    localparam int DrainCycles = 12;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [NumW-1:0]    number = '0;
    logic               busy;
    logic               strobe;
    logic [LetterW-1:0] letter;
    logic               range_error;
    logic               last;

    // Numbers waiting to be offered, and letters waiting to come out.
    logic [NumW-1:0] pending_numbers[$];
    glyph_t          expected_glyphs[$];

    int  total_numbers  = 0;
    int  accepted_count = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    int  gap_left       = 0;
    bit  number_taken   = 1'b0;
    bit  no_idle        = 1'b0;

    // Symbol tables per place: thousands, hundreds, tens, units.
    logic [LetterW-1:0] one_sym[4]  = '{LetM, LetC, LetX, LetI};
    logic [LetterW-1:0] five_sym[4] = '{LetNone, LetD, LetL, LetV};
    logic [LetterW-1:0] ten_sym[4]  = '{LetNone, LetM, LetC, LetX};

    binary_to_roman_numeral dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .number      (number),
        .busy        (busy),
        .strobe      (strobe),
        .letter      (letter),
        .range_error (range_error),
        .last        (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void add_letter(logic [LetterW-1:0] l);
        glyph_t g;
        g.letter      = l;
        g.range_error = 1'b0;
        g.last        = 1'b0;
        expected_glyphs.push_back(g);
    endfunction

    // Expands one accepted number into its expected letters.
    function automatic void predict_numeral(logic [NumW-1:0] value);
        int unsigned v;
        int unsigned dig[4];
        glyph_t      g;
        v = value;
        if (v < 1 || v > MaxValue)
        begin
            g.letter      = LetNone;
            g.range_error = 1'b1;
            g.last        = 1'b1;
            expected_glyphs.push_back(g);
            return;
        end
        dig[0] = v / 1000;
        dig[1] = (v % 1000) / 100;
        dig[2] = (v % 100) / 10;
        dig[3] = v % 10;
        for (int p = 0; p < 4; p++)
        begin
            case (dig[p])
                1, 2, 3:
                    repeat (dig[p]) add_letter(one_sym[p]);
                4:
                begin
                    add_letter(one_sym[p]);
                    add_letter(five_sym[p]);
                end
                5:
                    add_letter(five_sym[p]);
                6, 7, 8:
                begin
                    add_letter(five_sym[p]);
                    repeat (dig[p] - 5) add_letter(one_sym[p]);
                end
                9:
                begin
                    add_letter(one_sym[p]);
                    add_letter(ten_sym[p]);
                end
                default: ;
            endcase
        end
        // valid numbers always give at least one letter
        expected_glyphs[expected_glyphs.size() - 1].last = 1'b1;
    endfunction

    // Idle length before the next item: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 39) == 0)
            no_idle = !no_idle;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [NumW-1:0] random_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        else if (r < 10)
            return NumW'($urandom_range(4000, 4095));
        else if (r < 35)
            // digits 5..8 give the longest numerals
            return NumW'($urandom_range(1, 3) * 1000 + $urandom_range(5, 8) * 100
                         + $urandom_range(5, 8) * 10 + $urandom_range(5, 8));
        return NumW'($urandom_range(1, 3999));
    endfunction

    // Driver: inputs change on the falling edge. An offered item is held
    // until the monitor sees it taken, then an optional gap follows.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || number_taken)
        begin
            number_taken = 1'b0;
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_numbers.size() > 0)
            begin
                start  <= 1'b1;
                number <= pending_numbers.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: samples on the rising edge. Records accepted items, checks
    // every strobed letter against the oldest expectation.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("tb failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_numeral(number);
                accepted_count = accepted_count + 1;
                number_taken   = 1'b1;
                gap_left       = pick_gap();
            end
            if (strobe)
            begin
                if (expected_glyphs.size() == 0)
                begin
                    $error("unexpected letter %0h with nothing expected", letter);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    glyph_t want;
                    want = expected_glyphs.pop_front();
                    if (letter !== want.letter)
                    begin
                        $error("letter: expected %0h, got %0h", want.letter, letter);
                        mismatches = mismatches + 1;
                    end
                    if (range_error !== want.range_error)
                    begin
                        $error("range_error: expected %0b, got %0b",
                               want.range_error, range_error);
                        mismatches = mismatches + 1;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        // Directed: range edges, all-zero and all-one inputs, the 4, 5 and 9
        // digit shapes in the hundreds, tens and units places, and the longest numeral.
        pending_numbers.push_back(12'd0);
        pending_numbers.push_back(12'd1);
        pending_numbers.push_back(12'd3999);
        pending_numbers.push_back(12'd4000);
        pending_numbers.push_back(12'd4095);
        pending_numbers.push_back(12'd3888);
        pending_numbers.push_back(12'd4);
        pending_numbers.push_back(12'd5);
        pending_numbers.push_back(12'd9);
        pending_numbers.push_back(12'd10);
        pending_numbers.push_back(12'd40);
        pending_numbers.push_back(12'd50);
        pending_numbers.push_back(12'd90);
        pending_numbers.push_back(12'd400);
        pending_numbers.push_back(12'd500);
        pending_numbers.push_back(12'd900);
        pending_numbers.push_back(12'd1000);
        pending_numbers.push_back(12'd1994);
        pending_numbers.push_back(12'd2444);
        pending_numbers.push_back(12'd3767);
        pending_numbers.push_back(12'd2048);
        pending_numbers.push_back(12'd1365);
        repeat (RandomItems) pending_numbers.push_back(random_number());
        total_numbers = pending_numbers.size();

        // Reset once, released on a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_numbers || expected_glyphs.size() != 0)
            @(posedge clk);
        // Any stray letter after the last one would show up here.
        repeat (DrainCycles) @(posedge clk);

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
